// File: hw/rtl/hkt_pkg.sv
package hkt_pkg;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_DATA_W = 2;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_VARIANT   = 1'b1;

	localparam logic DIR_TO_STD   = 1'b0;
	localparam logic DIR_FROM_STD = 1'b1;

	localparam logic [1:0] VAR_SHIFT    = 2'd0;
	localparam logic [1:0] VAR_ESCAPE   = 2'd1;
	localparam logic [1:0] VAR_EIGHTBIT = 2'd2;
	localparam logic [1:0] VAR_RESERVED = 2'd3;

	localparam logic [7:0] BYTE_ESC         = 8'h1B;
	localparam logic [7:0] BYTE_LPAREN      = 8'h28;
	localparam logic [7:0] BYTE_KANA_FINAL  = 8'h49;
	localparam logic [7:0] BYTE_ROMAN_FINAL = 8'h4A;
	localparam logic [7:0] BYTE_SO          = 8'h0E;
	localparam logic [7:0] BYTE_SI          = 8'h0F;
	localparam logic [7:0] KANA_OFFSET      = 8'h80;

	typedef enum logic [2:0] {
		PRE_NONE  = 3'b001,
		PRE_ESC   = 3'b010,
		PRE_PAREN = 3'b100
	} prefix_t;

	typedef struct packed {
		logic [7:0] b2;
		logic [7:0] b1;
		logic [7:0] b0;
		logic [1:0] cnt;
	} emit_t;

	function automatic emit_t put_byte(emit_t e, logic [7:0] b);
		emit_t r;
		r = e;
		unique case (e.cnt)
			2'd0: begin
				r.b0  = b;
				r.cnt = 2'd1;
			end
			2'd1: begin
				r.b1  = b;
				r.cnt = 2'd2;
			end
			2'd2: begin
				r.b2  = b;
				r.cnt = 2'd3;
			end
			default: r = e;
		endcase
		return r;
	endfunction

endpackage

// File: hw/rtl/halfwidth_kana_escape_transcoder_core.sv
// Half-width katakana shift transcoder.
// The slave channel (s_tvalid/s_tready/s_tdata/s_tlast) takes one text byte
// per item; s_tlast marks the last byte of a stream, after which any held
// escape prefix is flushed and the stream state returns to idle.
// The master channel returns exactly one item per input item, carrying a
// byte count and up to three bytes in order from the lowest byte slot.
// Direction and variant are set through the write port (cfg_we, cfg_index,
// cfg_wdata); the user must write only while the block is idle, which the
// block itself does not enforce. Every write clears the stream state.
// There is one input register stage and one result register stage, with
// the per-byte decision logic between them; an accepted item's result is
// registered in the result stage before it shows on the master channel.
// Throughput is one item per cycle while the receiver takes results. The
// result register is refilled in the same cycle it is taken, so the block
// keeps accepting while a result waits. When the receiver stalls, the
// result register and then the input register hold, and s_tready drops
// once both are full. Reset clears the configuration to direction 0,
// variant 0 and empties both register stages and the stream state.
module halfwidth_kana_escape_transcoder_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [hkt_pkg::IN_DATA_W-1:0]    s_tdata,  // [7:0] in_byte
	input  logic                             s_tlast,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [1:0] out_count, [9:2] out_byte_first, [17:10] out_byte_second,
	// [25:18] out_byte_third, [31:26] zero
	output logic [hkt_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                             cfg_we,
	input  logic [hkt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hkt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import hkt_pkg::*;

	logic        dir_q;
	logic [1:0]  var_q;
	logic        kana_q;
	prefix_t     pre_q;
	logic [1:0]  pt_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        valid_s2;
	emit_t       emit_s2;

	logic        advance;
	emit_t       e;
	logic        kana_n;
	prefix_t     pre_n;
	logic [1:0]  pt_n;
	logic        matched;
	logic [7:0]  final_in;
	logic [7:0]  final_out;
	logic        run_match;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, emit_s2};

	always_comb begin
		e         = '0;
		kana_n    = kana_q;
		pre_n     = pre_q;
		pt_n      = pt_q;
		matched   = 1'b0;
		run_match = 1'b0;
		final_in  = (dir_q == DIR_FROM_STD) ? BYTE_KANA_FINAL : BYTE_ROMAN_FINAL;
		final_out = (dir_q == DIR_FROM_STD) ? BYTE_ROMAN_FINAL : BYTE_KANA_FINAL;

		if (var_q == VAR_SHIFT && dir_q == DIR_TO_STD) begin
			if (!kana_q) begin
				if (byte_s1 == BYTE_SO) begin
					e = put_byte(e, BYTE_ESC);
					e = put_byte(e, BYTE_LPAREN);
					e = put_byte(e, BYTE_KANA_FINAL);
					kana_n = 1'b1;
				end else begin
					e = put_byte(e, byte_s1);
				end
			end else if (byte_s1 == BYTE_SI) begin
				kana_n = 1'b0;
			end else begin
				e = put_byte(e, byte_s1);
			end
		end else if (var_q == VAR_SHIFT) begin
			final_in = BYTE_KANA_FINAL;
			if (kana_q) begin
				if (byte_s1 == BYTE_ESC) begin
					e = put_byte(e, BYTE_SI);
					e = put_byte(e, BYTE_ESC);
					kana_n = 1'b0;
					pt_n   = 2'd2;
				end else begin
					e = put_byte(e, byte_s1);
				end
			end else if (pt_q != 2'd0) begin
				e    = put_byte(e, byte_s1);
				pt_n = pt_q - 2'd1;
			end else begin
				run_match = 1'b1;
			end
		end else if (var_q == VAR_EIGHTBIT) begin
			if (kana_q) begin
				if (byte_s1 == BYTE_ESC) begin
					kana_n = 1'b0;
					pre_n  = PRE_ESC;
				end else begin
					e = put_byte(e, byte_s1 ^ KANA_OFFSET);
				end
			end else begin
				run_match = 1'b1;
			end
		end else begin
			e = put_byte(e, byte_s1);
		end

		if (run_match) begin
			unique case (pre_q)
				PRE_NONE: begin
					if (byte_s1 == BYTE_ESC) begin
						pre_n = PRE_ESC;
					end else begin
						e = put_byte(e, byte_s1);
					end
				end
				PRE_ESC: begin
					if (byte_s1 == BYTE_LPAREN) begin
						pre_n = PRE_PAREN;
					end else if (byte_s1 == BYTE_ESC) begin
						e = put_byte(e, BYTE_ESC);
					end else begin
						e     = put_byte(e, BYTE_ESC);
						e     = put_byte(e, byte_s1);
						pre_n = PRE_NONE;
					end
				end
				default: begin
					if (byte_s1 == final_in) begin
						pre_n   = PRE_NONE;
						matched = 1'b1;
					end else begin
						e = put_byte(e, BYTE_ESC);
						e = put_byte(e, BYTE_LPAREN);
						if (byte_s1 == BYTE_ESC) begin
							pre_n = PRE_ESC;
						end else begin
							e     = put_byte(e, byte_s1);
							pre_n = PRE_NONE;
						end
					end
				end
			endcase
			if (matched) begin
				kana_n = 1'b1;
				if (var_q == VAR_SHIFT) begin
					e = put_byte(e, BYTE_SO);
				end else begin
					e = put_byte(e, BYTE_ESC);
					e = put_byte(e, BYTE_LPAREN);
					e = put_byte(e, final_out);
				end
			end
		end

		if (last_s1) begin
			if (pre_n == PRE_ESC || pre_n == PRE_PAREN) begin
				e = put_byte(e, BYTE_ESC);
			end
			if (pre_n == PRE_PAREN) begin
				e = put_byte(e, BYTE_LPAREN);
			end
			if (var_q == VAR_SHIFT && dir_q == DIR_FROM_STD && kana_n) begin
				e = put_byte(e, BYTE_SI);
			end
			kana_n = 1'b0;
			pre_n  = PRE_NONE;
			pt_n   = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= DIR_TO_STD;
			var_q    <= VAR_SHIFT;
			kana_q   <= 1'b0;
			pre_q    <= PRE_NONE;
			pt_q     <= 2'd0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DIRECTION: dir_q <= cfg_wdata[0];
					REG_VARIANT:   var_q <= cfg_wdata;
				endcase
				kana_q <= 1'b0;
				pre_q  <= PRE_NONE;
				pt_q   <= 2'd0;
			end else if (advance) begin
				kana_q <= kana_n;
				pre_q  <= pre_n;
				pt_q   <= pt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (advance) begin
			emit_s2 <= e;
		end
	end

`ifndef ASSERT_OFF
	a_pt_outside_kana: assert property (@(posedge clk) disable iff (!arst_n)
		pt_q != 2'd0 |-> !kana_q && var_q == VAR_SHIFT && dir_q == DIR_FROM_STD)
		else $error("Closing escape copy active outside shift-in reverse mode.");

	a_kana_no_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		kana_q |-> pre_q == PRE_NONE)
		else $error("Escape prefix held while inside a kana run.");

	a_escape_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(var_q == VAR_ESCAPE || var_q == VAR_RESERVED) |-> !kana_q && pre_q == PRE_NONE)
		else $error("Stream state left idle in pass-through variant.");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> !kana_q && pre_q == PRE_NONE && pt_q == 2'd0)
		else $error("Stream state not cleared after the last item.");

	a_stage_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_tready |=> valid_s1 && valid_s2)
		else $error("A stalled item was dropped from the pipeline.");
`endif

endmodule
